### hdl/dfst_pkg.sv
// Shared types and codes for the depth-first search time stamp block.
package dfst_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] src_vertex;
    logic [5:0] dst_vertex;
  } dfst_in_t;

  typedef struct packed {
    logic [5:0] vertex_index;
    logic [7:0] discover_stamp;
    logic [7:0] finish_stamp;
    logic [5:0] parent_vertex;
    logic       has_parent;
    logic [1:0] status;
    logic       last;
  } dfst_out_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_ADD_RD,
    FSM_ADD_LINK,
    FSM_ACK,
    FSM_ROOT,
    FSM_DISC,
    FSM_STEP,
    FSM_EDGE,
    FSM_POP,
    FSM_ORD,
    FSM_OSEND
  } dfst_fsm_t;

endpackage

### hdl/dfst_graph_store.sv
// Adjacency storage: per-vertex list head and tail, edge target and link tables.
module dfst_graph_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int EW = $clog2(MAX_EDGES),
  localparam int LW = EW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ht_clear,
  input  logic [VW-1:0] ht_rd_addr,
  output logic          ht_rd_vld,
  output logic [EW-1:0] ht_rd_head,
  output logic [EW-1:0] ht_rd_tail,
  input  logic          ht_we,
  input  logic [VW-1:0] ht_wr_addr,
  input  logic [EW-1:0] ht_wr_head,
  input  logic [EW-1:0] ht_wr_tail,
  input  logic [EW-1:0] e_rd_addr,
  output logic [VW-1:0] e_rd_tgt,
  output logic [LW-1:0] e_rd_lnk,
  input  logic          tgt_we,
  input  logic [EW-1:0] tgt_wr_addr,
  input  logic [VW-1:0] tgt_wr_data,
  input  logic          lnk_we,
  input  logic [EW-1:0] lnk_wr_addr,
  input  logic [LW-1:0] lnk_wr_data
);

  logic [2*EW-1:0]         ht_mem [MAX_VERTICES];
  logic [VW-1:0]           tgt_mem [MAX_EDGES];
  logic [LW-1:0]           lnk_mem [MAX_EDGES];
  logic [MAX_VERTICES-1:0] ht_vld_r;
  logic                    ht_rd_vld_r;
  logic [2*EW-1:0]         ht_rd_r;
  logic [VW-1:0]           tgt_rd_r;
  logic [LW-1:0]           lnk_rd_r;

  always_ff @(posedge clk) begin
    if (ht_we) begin
      ht_mem[ht_wr_addr] <= {ht_wr_head, ht_wr_tail};
    end
    ht_rd_r <= ht_mem[ht_rd_addr];
    if (tgt_we) begin
      tgt_mem[tgt_wr_addr] <= tgt_wr_data;
    end
    if (lnk_we) begin
      lnk_mem[lnk_wr_addr] <= lnk_wr_data;
    end
    tgt_rd_r <= tgt_mem[e_rd_addr];
    lnk_rd_r <= lnk_mem[e_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ht_clear) begin
      ht_vld_r    <= '0;
      ht_rd_vld_r <= 1'b0;
    end else begin
      if (ht_we) begin
        ht_vld_r[ht_wr_addr] <= 1'b1;
      end
      ht_rd_vld_r <= ht_vld_r[ht_rd_addr];
    end
  end

  assign ht_rd_vld  = ht_rd_vld_r;
  assign ht_rd_head = ht_rd_r[2*EW-1:EW];
  assign ht_rd_tail = ht_rd_r[EW-1:0];
  assign e_rd_tgt   = tgt_rd_r;
  assign e_rd_lnk   = lnk_rd_r;

endmodule

### hdl/dfst_vertex_store.sv
// Per-vertex search records (discovery, parent, finish) and the walk stack.
module dfst_vertex_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int EW = $clog2(MAX_EDGES),
  localparam int LW = EW + 1
) (
  input  logic          clk,
  input  logic [VW-1:0] v_rd_addr,
  output logic [7:0]    v_rd_disc,
  output logic          v_rd_hasp,
  output logic [VW-1:0] v_rd_par,
  output logic [7:0]    v_rd_fin,
  input  logic          vi_we,
  input  logic [VW-1:0] vi_wr_addr,
  input  logic [7:0]    vi_wr_disc,
  input  logic          vi_wr_hasp,
  input  logic [VW-1:0] vi_wr_par,
  input  logic          fin_we,
  input  logic [VW-1:0] fin_wr_addr,
  input  logic [7:0]    fin_wr_data,
  input  logic [VW-1:0] stk_rd_addr,
  output logic [VW-1:0] stk_rd_vtx,
  output logic [LW-1:0] stk_rd_cur,
  input  logic          stk_we,
  input  logic [VW-1:0] stk_wr_addr,
  input  logic [VW-1:0] stk_wr_vtx,
  input  logic [LW-1:0] stk_wr_cur
);

  logic [8+VW:0]    vi_mem [MAX_VERTICES];
  logic [7:0]       fin_mem [MAX_VERTICES];
  logic [VW+LW-1:0] stk_mem [MAX_VERTICES];
  logic [8+VW:0]    vi_rd_r;
  logic [7:0]       fin_rd_r;
  logic [VW+LW-1:0] stk_rd_r;

  always_ff @(posedge clk) begin
    if (vi_we) begin
      vi_mem[vi_wr_addr] <= {vi_wr_disc, vi_wr_hasp, vi_wr_par};
    end
    if (fin_we) begin
      fin_mem[fin_wr_addr] <= fin_wr_data;
    end
    if (stk_we) begin
      stk_mem[stk_wr_addr] <= {stk_wr_vtx, stk_wr_cur};
    end
    vi_rd_r  <= vi_mem[v_rd_addr];
    fin_rd_r <= fin_mem[v_rd_addr];
    stk_rd_r <= stk_mem[stk_rd_addr];
  end

  assign v_rd_disc  = vi_rd_r[8+VW:VW+1];
  assign v_rd_hasp  = vi_rd_r[VW];
  assign v_rd_par   = vi_rd_r[VW-1:0];
  assign v_rd_fin   = fin_rd_r;
  assign stk_rd_vtx = stk_rd_r[VW+LW-1:LW];
  assign stk_rd_cur = stk_rd_r[LW-1:0];

endmodule

### hdl/depth_first_search_timestamps_top.sv
// Top level: request sequencer for graph loading, depth-first search and result readout.
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data    | add edge, run, clear requests
//  result   | out_valid, out_ready, out_data | acks and per-vertex records
//  config   | cfg_we, cfg_wdata              | vertex count
//
// Add edge: list read, table write, link write, ack. Clear: list valid bits and edge fill reset, then ack.
// Run: vertex discoveries, edge scans and finishes, then one result record per vertex;
// the graph and vertex memories all return their read data through a register.
// Reset is synchronous; no clearing pass, list heads carry valid bits.
// A stalled result register holds the sequencer; requests wait while a run is busy.
module depth_first_search_timestamps_top
  import dfst_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dfst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dfst_out_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int LW = EW + 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [LW-1:0] LNONE = LW'(MAX_EDGES);

  dfst_fsm_t state_r, state_nxt;
  logic [6:0]              cnt_r;
  logic [EW:0]             fill_r, fill_nxt;
  logic [7:0]              clk_r, clk_nxt;
  logic [CW-1:0]           s_r, s_nxt, sp_r, sp_nxt;
  logic [VW-1:0]           top_vtx_r, top_vtx_nxt, pend_r, pend_nxt;
  logic [LW-1:0]           top_cur_r, top_cur_nxt;
  logic [VW-1:0]           src_r, src_nxt, dst_r, dst_nxt, o_r, o_nxt;
  logic [EW-1:0]           tail_r, tail_nxt;
  logic                    link_r, link_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic                    out_valid_r, out_valid_nxt;
  dfst_out_t               out_data_r, out_data_nxt;

  logic [CW-1:0] eff_n;
  logic          out_free, acc, bad_rng, cur_ok, tgt_ok;

  logic          ht_clear, ht_rd_vld, ht_we;
  logic [VW-1:0] ht_rd_addr, ht_wr_addr;
  logic [EW-1:0] ht_rd_head, ht_rd_tail, ht_wr_head, ht_wr_tail;
  logic [EW-1:0] e_rd_addr, tgt_wr_addr, lnk_wr_addr;
  logic [VW-1:0] e_rd_tgt, tgt_wr_data;
  logic [LW-1:0] e_rd_lnk, lnk_wr_data;
  logic          tgt_we, lnk_we;

  logic [VW-1:0] v_rd_addr, v_rd_par, vi_wr_addr, vi_wr_par, fin_wr_addr;
  logic [7:0]    v_rd_disc, v_rd_fin, vi_wr_disc, fin_wr_data;
  logic          v_rd_hasp, vi_we, vi_wr_hasp, fin_we, stk_we;
  logic [VW-1:0] stk_rd_addr, stk_rd_vtx, stk_wr_addr, stk_wr_vtx;
  logic [LW-1:0] stk_rd_cur, stk_wr_cur;

  dfst_graph_store #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_graph (
    .clk, .rst_n, .ht_clear, .ht_rd_addr, .ht_rd_vld, .ht_rd_head, .ht_rd_tail,
    .ht_we, .ht_wr_addr, .ht_wr_head, .ht_wr_tail, .e_rd_addr, .e_rd_tgt, .e_rd_lnk,
    .tgt_we, .tgt_wr_addr, .tgt_wr_data, .lnk_we, .lnk_wr_addr, .lnk_wr_data
  );

  dfst_vertex_store #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_vertex (
    .clk, .v_rd_addr, .v_rd_disc, .v_rd_hasp, .v_rd_par, .v_rd_fin,
    .vi_we, .vi_wr_addr, .vi_wr_disc, .vi_wr_hasp, .vi_wr_par,
    .fin_we, .fin_wr_addr, .fin_wr_data, .stk_rd_addr, .stk_rd_vtx, .stk_rd_cur,
    .stk_we, .stk_wr_addr, .stk_wr_vtx, .stk_wr_cur
  );

  always_comb begin
    if (cnt_r == 7'd0) begin
      eff_n = CW'(1);
    end else if (cnt_r > 7'(MAX_VERTICES)) begin
      eff_n = CW'(MAX_VERTICES);
    end else begin
      eff_n = CW'(cnt_r);
    end
  end

  assign in_ready = (state_r == FSM_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign bad_rng  = (7'(in_data.src_vertex) >= 7'(eff_n)) ||
                    (7'(in_data.dst_vertex) >= 7'(eff_n));
  assign cur_ok   = top_cur_r < LNONE;
  assign tgt_ok   = (CW'(e_rd_tgt) < eff_n) && !vis_r[e_rd_tgt];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (acc) begin
          case (in_data.req_type)
            REQ_ADD: begin
              if (bad_rng || fill_r >= (EW+1)'(MAX_EDGES)) begin
                state_nxt = FSM_ACK;
              end else begin
                state_nxt = FSM_ADD_RD;
              end
            end
            REQ_RUN:   state_nxt = FSM_ROOT;
            REQ_CLEAR: state_nxt = FSM_ACK;
            default:   state_nxt = FSM_IDLE;
          endcase
        end
      end
      FSM_ADD_RD:   state_nxt = FSM_ADD_LINK;
      FSM_ADD_LINK: state_nxt = FSM_ACK;
      FSM_ACK: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_ROOT: begin
        if (s_r == eff_n) begin
          state_nxt = FSM_ORD;
        end else if (!vis_r[s_r[VW-1:0]]) begin
          state_nxt = FSM_DISC;
        end
      end
      FSM_DISC: state_nxt = FSM_STEP;
      FSM_STEP: begin
        if (cur_ok) begin
          state_nxt = FSM_EDGE;
        end else if (sp_r > CW'(1)) begin
          state_nxt = FSM_POP;
        end else begin
          state_nxt = FSM_ROOT;
        end
      end
      FSM_EDGE:  state_nxt = tgt_ok ? FSM_DISC : FSM_STEP;
      FSM_POP:   state_nxt = FSM_STEP;
      FSM_ORD:   state_nxt = FSM_OSEND;
      FSM_OSEND: begin
        if (out_free) begin
          state_nxt = (CW'(o_r) == eff_n - CW'(1)) ? FSM_IDLE : FSM_ORD;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    fill_nxt    = fill_r;
    clk_nxt     = clk_r;
    s_nxt       = s_r;
    sp_nxt      = sp_r;
    top_vtx_nxt = top_vtx_r;
    top_cur_nxt = top_cur_r;
    pend_nxt    = pend_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    o_nxt       = o_r;
    tail_nxt    = tail_r;
    link_nxt    = link_r;
    status_nxt  = status_r;
    vis_nxt     = vis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    ht_clear    = 1'b0;
    ht_rd_addr  = in_data.src_vertex[VW-1:0];
    ht_we       = 1'b0;
    ht_wr_addr  = src_r;
    ht_wr_head  = ht_rd_vld ? ht_rd_head : fill_r[EW-1:0];
    ht_wr_tail  = fill_r[EW-1:0];
    e_rd_addr   = top_cur_r[EW-1:0];
    tgt_we      = 1'b0;
    tgt_wr_addr = fill_r[EW-1:0];
    tgt_wr_data = dst_r;
    lnk_we      = 1'b0;
    lnk_wr_addr = fill_r[EW-1:0];
    lnk_wr_data = LNONE;
    v_rd_addr   = o_r;
    vi_we       = 1'b0;
    vi_wr_addr  = s_r[VW-1:0];
    vi_wr_disc  = clk_r + 8'd1;
    vi_wr_hasp  = 1'b0;
    vi_wr_par   = '0;
    fin_we      = 1'b0;
    fin_wr_addr = top_vtx_r;
    fin_wr_data = clk_r + 8'd1;
    stk_rd_addr = VW'(sp_r - CW'(2));
    stk_we      = 1'b0;
    stk_wr_addr = VW'(sp_r - CW'(1));
    stk_wr_vtx  = top_vtx_r;
    stk_wr_cur  = top_cur_r;

    case (state_r)
      FSM_IDLE: begin
        if (acc) begin
          src_nxt    = in_data.src_vertex[VW-1:0];
          dst_nxt    = in_data.dst_vertex[VW-1:0];
          status_nxt = ST_OK;
          case (in_data.req_type)
            REQ_ADD: begin
              if (bad_rng) begin
                status_nxt = ST_RANGE;
              end else if (fill_r >= (EW+1)'(MAX_EDGES)) begin
                status_nxt = ST_FULL;
              end
            end
            REQ_RUN: begin
              vis_nxt = '0;
              clk_nxt = '0;
              s_nxt   = '0;
              sp_nxt  = '0;
              o_nxt   = '0;
            end
            REQ_CLEAR: begin
              ht_clear = 1'b1;
              fill_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      FSM_ADD_RD: begin
        ht_we    = 1'b1;
        tgt_we   = 1'b1;
        lnk_we   = 1'b1;
        link_nxt = ht_rd_vld;
        tail_nxt = ht_rd_tail;
      end
      FSM_ADD_LINK: begin
        lnk_we      = link_r;
        lnk_wr_addr = tail_r;
        lnk_wr_data = LW'(fill_r[EW-1:0]);
        fill_nxt    = fill_r + 1'b1;
      end
      FSM_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{vertex_index: '0, discover_stamp: '0, finish_stamp: '0,
                            parent_vertex: '0, has_parent: 1'b0, status: status_r,
                            last: 1'b1};
        end
      end
      FSM_ROOT: begin
        ht_rd_addr = s_r[VW-1:0];
        if (s_r != eff_n) begin
          if (vis_r[s_r[VW-1:0]]) begin
            s_nxt = s_r + CW'(1);
          end else begin
            vi_we    = 1'b1;
            clk_nxt  = clk_r + 8'd1;
            pend_nxt = s_r[VW-1:0];
            vis_nxt[s_r[VW-1:0]] = 1'b1;
          end
        end
      end
      FSM_DISC: begin
        stk_we      = (sp_r != '0);
        sp_nxt      = sp_r + CW'(1);
        top_vtx_nxt = pend_r;
        top_cur_nxt = ht_rd_vld ? LW'(ht_rd_head) : LNONE;
      end
      FSM_STEP: begin
        if (!cur_ok) begin
          fin_we  = 1'b1;
          clk_nxt = clk_r + 8'd1;
          sp_nxt  = sp_r - CW'(1);
        end
      end
      FSM_EDGE: begin
        ht_rd_addr  = e_rd_tgt;
        top_cur_nxt = e_rd_lnk;
        if (tgt_ok) begin
          vi_we      = 1'b1;
          vi_wr_addr = e_rd_tgt;
          vi_wr_hasp = 1'b1;
          vi_wr_par  = top_vtx_r;
          clk_nxt    = clk_r + 8'd1;
          pend_nxt   = e_rd_tgt;
          vis_nxt[e_rd_tgt] = 1'b1;
        end
      end
      FSM_POP: begin
        stk_rd_addr = VW'(sp_r - CW'(1));
        top_vtx_nxt = stk_rd_vtx;
        top_cur_nxt = stk_rd_cur;
      end
      FSM_OSEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{vertex_index: 6'(o_r), discover_stamp: v_rd_disc,
                            finish_stamp: v_rd_fin,
                            parent_vertex: v_rd_hasp ? 6'(v_rd_par) : 6'd0,
                            has_parent: v_rd_hasp, status: ST_OK,
                            last: (CW'(o_r) == eff_n - CW'(1))};
          o_nxt = o_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= 7'(MAX_VERTICES);
      fill_r      <= '0;
      clk_r       <= '0;
      s_r         <= '0;
      sp_r        <= '0;
      link_r      <= 1'b0;
      vis_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      clk_r       <= clk_nxt;
      s_r         <= s_nxt;
      sp_r        <= sp_nxt;
      link_r      <= link_nxt;
      vis_r       <= vis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_vtx_r  <= top_vtx_nxt;
    top_cur_r  <= top_cur_nxt;
    pend_r     <= pend_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    o_r        <= o_nxt;
    tail_r     <= tail_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/depth_first_search_timestamps_top_tb.sv
// Testbench for the depth-first search time stamp block: driver, monitor and predictor.
module depth_first_search_timestamps_top_tb;
  import dfst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dfst_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dfst_out_t out_data;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  depth_first_search_timestamps_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // graph model
  logic [6:0] vcount;
  logic [5:0] tgt [NE];
  int unsigned lnk [NE];
  int unsigned head [NV];
  int unsigned tail [NV];
  int unsigned fill;

  dfst_in_t pending_q[$];
  dfst_out_t expected_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  bit in_taken = 0;
  int quiet = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned live_count();
    if (vcount == 0) return 1;
    if (vcount > NV) return NV;
    return vcount;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < NV; i++) begin
      head[i] = NE;
      tail[i] = NE;
    end
    fill = 0;
  endfunction

  function automatic void push_ack(logic [1:0] st);
    dfst_out_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_search(int unsigned n);
    int unsigned clr [NV];
    int unsigned par [NV];
    logic [7:0] dsc [NV];
    logic [7:0] fin [NV];
    int unsigned stk_v [NV];
    int unsigned stk_c [NV];
    int unsigned sp;
    int unsigned u, e, v;
    logic [7:0] stamp;
    dfst_out_t r;
    sp = 0;
    stamp = 0;
    for (int i = 0; i < NV; i++) begin
      clr[i] = 0;
      par[i] = NV;
      dsc[i] = 0;
      fin[i] = 0;
    end
    for (int s = 0; s < n; s++) begin
      if (clr[s] != 0) continue;
      stamp++;
      dsc[s] = stamp;
      clr[s] = 1;
      stk_v[sp] = s;
      stk_c[sp] = head[s];
      sp++;
      while (sp > 0) begin
        u = stk_v[sp-1];
        e = stk_c[sp-1];
        if (e < NE) begin
          v = tgt[e];
          stk_c[sp-1] = lnk[e];
          if (v < n && clr[v] == 0) begin
            par[v] = u;
            stamp++;
            dsc[v] = stamp;
            clr[v] = 1;
            if (sp < NV) begin
              stk_v[sp] = v;
              stk_c[sp] = head[v];
              sp++;
            end
          end
        end else begin
          clr[u] = 2;
          stamp++;
          fin[u] = stamp;
          sp--;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.vertex_index = i[5:0];
      r.discover_stamp = dsc[i];
      r.finish_stamp = fin[i];
      r.has_parent = par[i] < NV;
      r.parent_vertex = r.has_parent ? par[i][5:0] : 6'd0;
      r.status = ST_OK;
      r.last = (i + 1 == n);
      expected_q.push_back(r);
    end
  endfunction

  function automatic void predict(dfst_in_t t);
    int unsigned n;
    n = live_count();
    case (t.req_type)
      REQ_ADD: begin
        if (t.src_vertex >= n || t.dst_vertex >= n) push_ack(ST_RANGE);
        else if (fill >= NE) push_ack(ST_FULL);
        else begin
          tgt[fill] = t.dst_vertex;
          lnk[fill] = NE;
          if (tail[t.src_vertex] >= NE) head[t.src_vertex] = fill;
          else lnk[tail[t.src_vertex]] = fill;
          tail[t.src_vertex] = fill;
          fill++;
          push_ack(ST_OK);
        end
      end
      REQ_RUN: predict_search(n);
      REQ_CLEAR: begin
        clear_graph();
        push_ack(ST_OK);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_q.size() > 0 && !hold_off &&
            ($urandom_range(99) >= send_idle)) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (in_valid && in_ready) begin
        predict(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", out_data.vertex_index, 0);
        end else begin
          dfst_out_t w;
          w = expected_q.pop_front();
          if (out_data.vertex_index !== w.vertex_index)
            report("vertex_index", out_data.vertex_index, w.vertex_index);
          if (out_data.discover_stamp !== w.discover_stamp)
            report("discover_stamp", out_data.discover_stamp, w.discover_stamp);
          if (out_data.finish_stamp !== w.finish_stamp)
            report("finish_stamp", out_data.finish_stamp, w.finish_stamp);
          if (out_data.parent_vertex !== w.parent_vertex)
            report("parent_vertex", out_data.parent_vertex, w.parent_vertex);
          if (out_data.has_parent !== w.has_parent)
            report("has_parent", out_data.has_parent, w.has_parent);
          if (out_data.status !== w.status)
            report("status", out_data.status, w.status);
          if (out_data.last !== w.last)
            report("last", out_data.last, w.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("depth_first_search_timestamps_top test failed");
      $finish;
    end
  end

  function automatic dfst_in_t mk(logic [1:0] rq, logic [5:0] s, logic [5:0] d);
    dfst_in_t t;
    t.req_type = rq;
    t.src_vertex = s;
    t.dst_vertex = d;
    return t;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    vcount = c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random graph: mostly in-range edges, a run, sometimes clear or noise
  task automatic random_graph(int unsigned n_edges, int unsigned span);
    int unsigned k;
    for (int i = 0; i < n_edges; i++) begin
      k = $urandom_range(99);
      if (k < 85)
        pending_q.push_back(mk(REQ_ADD, 6'($urandom_range(span - 1)),
                               6'($urandom_range(span - 1))));
      else if (k < 93)
        pending_q.push_back(mk(REQ_ADD, 6'($urandom), 6'($urandom)));
      else if (k < 96)
        pending_q.push_back(mk(REQ_UNUSED, 6'($urandom), 6'($urandom)));
      else
        pending_q.push_back(mk(REQ_CLEAR, 6'($urandom), 6'($urandom)));
    end
    pending_q.push_back(mk(REQ_RUN, 6'($urandom), 6'($urandom)));
  endtask

  initial begin
    int idle_sets [4][2];
    idle_sets = '{'{0, 0}, '{84, 0}, '{0, 84}, '{11, 11}};
    vcount = NV;
    clear_graph();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: runs on empty graph, range errors, chains, stale edges
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    pending_q.push_back(mk(REQ_ADD, 63, 0));
    pending_q.push_back(mk(REQ_ADD, 0, 63));
    pending_q.push_back(mk(REQ_ADD, 0, 1));
    pending_q.push_back(mk(REQ_ADD, 1, 2));
    pending_q.push_back(mk(REQ_ADD, 2, 0));
    pending_q.push_back(mk(REQ_ADD, 0, 0));
    pending_q.push_back(mk(REQ_UNUSED, 63, 63));
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    drain();
    set_count(7'd3);
    pending_q.push_back(mk(REQ_ADD, 3, 0));
    pending_q.push_back(mk(REQ_ADD, 0, 3));
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    drain();
    set_count(7'd0);
    pending_q.push_back(mk(REQ_ADD, 1, 0));
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    pending_q.push_back(mk(REQ_CLEAR, 63, 63));
    drain();
    set_count(7'd127);
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    pending_q.push_back(mk(REQ_ADD, 5, 6));
    pending_q.push_back(mk(REQ_ADD, 64 - 1, 64 - 1));
    pending_q.push_back(mk(REQ_RUN, 0, 0));
    pending_q.push_back(mk(REQ_CLEAR, 0, 0));
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned c;
      send_idle = idle_sets[ph % 4][0];
      recv_stall = idle_sets[ph % 4][1];
      c = (ph == 3) ? 1 : (ph == 5) ? 64 : $urandom_range(2, 20);
      set_count(c[6:0]);
      pending_q.push_back(mk(REQ_CLEAR, 6'($urandom), 6'($urandom)));
      random_graph($urandom_range(8, 24), c);
      if (ph == 2) begin
        while (pending_q.size() > 0 || in_valid) @(posedge clk);
        hold_off = 1;
        while (expected_q.size() > 0) @(posedge clk);
        hold_off = 0;
        random_graph(6, c);
      end
      drain();
    end

    if (errors == 0) begin
      $display("depth_first_search_timestamps_top test passed");
    end else begin
      $display("depth_first_search_timestamps_top test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/dfst_pkg.sv
hdl/dfst_graph_store.sv
hdl/dfst_vertex_store.sv
hdl/depth_first_search_timestamps_top.sv
sim/depth_first_search_timestamps_top_tb.sv
